// ----- sv/cdq_pkg.sv -----
// Shared types and constants for the circular double-ended queue.
package cdq_pkg;

  // Default number of words the queue holds.
  localparam int CDQ_CAPACITY = 16;

  // Word and field widths.
  localparam int WORD_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  // Action codes carried by an input beat.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4
  } action_t;

  // Status codes returned with each result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_REPORT = 1'b1
  } state_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic              shift_right;
    logic              shift_left;
    logic              load_back;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- sv/cdq_cell.sv -----
// One cell of the word row: holds one queue word and trades it with its neighbors.
module cdq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                       clk,
  input  cdq_pkg::cell_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]           count,
  input  logic [cdq_pkg::WORD_W-1:0] left_word,
  input  logic [cdq_pkg::WORD_W-1:0] right_word,
  input  logic [cdq_pkg::WORD_W-1:0] tap_in,
  output logic [cdq_pkg::WORD_W-1:0] word,
  output logic [cdq_pkg::WORD_W-1:0] tap_out
);
  import cdq_pkg::*;

  logic [WORD_W-1:0] word_next;
  logic              is_back;
  logic              is_free;

  // This cell is the back word when the count reaches just past it.
  assign is_back = (count == CNT_W'(IDX + 1));
  // This cell is the first free slot when the count equals its position.
  assign is_free = (count == CNT_W'(IDX));

  // Next word: shift toward the back, toward the front, or take a back push.
  always_comb begin
    priority if (ctrl.shift_right) begin
      word_next = left_word;
    end else if (ctrl.shift_left) begin
      word_next = right_word;
    end else if (ctrl.load_back && is_free) begin
      word_next = ctrl.value;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // The back word travels down the tap chain toward cell zero.
  assign tap_out = tap_in | (is_back ? word : '0);

endmodule

// ----- sv/circular_double_ended_queue.sv -----
// Circular double-ended queue built from a row of shifting word cells.
// Each input beat yields one result beat; a new beat is taken only after the
// result of the last one is loaded. The row updates at the accept edge and the
// result register loads afterwards, once the output register is free.
// Reset (rst, synchronous, active high) empties the queue and drops any result;
// the cell words themselves are not cleared.
module circular_double_ended_queue #(
  parameter int CAPACITY = cdq_pkg::CDQ_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int OUT_RAW  = 3 * cdq_pkg::WORD_W + cdq_pkg::STATUS_W + CNT_W,
  parameter int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // s_tdata fields from bit 0: action[2:0], value[34:3], zero fill.
  input  logic [39:0]      s_tdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  // m_tdata fields from bit 0: popped, status, count, front_word, back_word, zero fill.
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tvalid,
  input  logic             m_tready
);
  import cdq_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  held_next;
  logic [WORD_W-1:0] pend_popped;
  logic [WORD_W-1:0] popped_next;
  status_t           pend_status;
  status_t           status_next;

  logic [WORD_W-1:0] out_popped;
  status_t           out_status;
  logic [CNT_W-1:0]  out_count;
  logic [WORD_W-1:0] out_front;
  logic [WORD_W-1:0] out_back;

  action_t           in_action;
  logic [WORD_W-1:0] in_value;
  logic              in_fire;
  logic              out_free;
  logic              load_result;
  logic              is_full;
  logic              is_empty;
  cell_ctrl_t        ctrl;

  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [WORD_W-1:0] tap_chain [CAPACITY+1];

  // Input beat unpacking.
  assign in_action = action_t'(s_tdata[2:0]);
  assign in_value  = s_tdata[34:3];
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign is_full   = (held == CNT_W'(CAPACITY));
  assign is_empty  = (held == '0);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready    = (state == S_IDLE);
    load_result = (state == S_REPORT) && out_free;
  end

  // Decode the action into cell control, the new count and the pending result.
  always_comb begin
    ctrl.shift_right = 1'b0;
    ctrl.shift_left  = 1'b0;
    ctrl.load_back   = 1'b0;
    ctrl.value       = in_value;
    held_next        = held;
    popped_next      = '0;
    status_next      = ST_DONE;
    if (in_fire) begin
      unique case (in_action)
        ACT_PUSH_FRONT: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.shift_right = 1'b1;
            held_next        = held + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.load_back = 1'b1;
            held_next      = held + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            popped_next     = cell_word[0];
            ctrl.shift_left = 1'b1;
            held_next       = held - 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            popped_next = tap_chain[0];
            held_next   = held - 1'b1;
          end
        end
        ACT_CLEAR: begin
          held_next = '0;
        end
        default: begin
          held_next = held;
        end
      endcase
    end
  end

  // Row of word cells; the back word is collected along the tap chain.
  assign tap_chain[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = in_value;
    end else begin : g_inner_left
      assign left_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner_right
      assign right_word = cell_word[i+1];
    end

    cdq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (held),
      .left_word  (left_word),
      .right_word (right_word),
      .tap_in     (tap_chain[i+1]),
      .word       (cell_word[i]),
      .tap_out    (tap_chain[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      held  <= held_next;
      if (load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Pending result parts captured when the beat is taken.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_popped <= popped_next;
      pend_status <= status_next;
    end
  end

  // Result register, loaded from the updated row.
  always_ff @(posedge clk) begin
    if (load_result) begin
      out_popped <= pend_popped;
      out_status <= pend_status;
      out_count  <= held;
      out_front  <= is_empty ? '0 : cell_word[0];
      out_back   <= tap_chain[0];
    end
  end

  // Result beat packing.
  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_RAW-1:0] = {out_back, out_front, out_count, out_status, out_popped};
  end

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) held <= CNT_W'(CAPACITY))
    else $error("queue count exceeds capacity");

  // A taken beat always moves the sequencer to the report state.
  assert property (@(posedge clk) disable iff (rst) in_fire |=> state == S_REPORT)
    else $error("accepted beat did not start a report");

  // A loaded result carries the count after the step.
  assert property (@(posedge clk) disable iff (rst)
    load_result |=> (m_tvalid && out_count == $past(held)))
    else $error("result count does not match queue count");

  // An empty queue reports zero end words.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_count == '0) |-> (out_front == '0 && out_back == '0))
    else $error("empty queue reported nonzero end words");

  // A refused push only happens on a full queue.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_FULL) |-> out_count == CNT_W'(CAPACITY))
    else $error("full status reported on a queue that is not full");

endmodule
